[hw/rtl/lrle_pkg.sv]
`timescale 1ns / 1ps

package lrle_pkg;

	localparam int COORD_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int WIDE_BITS  = COORD_BITS + 4;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_LINE  = 8'd36;
	localparam logic [7:0] CH_LIVE  = 8'd111;
	localparam logic [7:0] CH_END   = 8'd33;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [FIELD_BITS-1:0] field_t;

	typedef struct packed {
		coord_t pending;
		coord_t column;
		coord_t row;
		logic   finished;
	} dec_state_t;

	typedef struct packed {
		field_t start_column;
		field_t row_index;
		field_t live_count;
		logic   pattern_end;
	} run_rec_t;

endpackage

[hw/rtl/lrle_step.sv]
`timescale 1ns / 1ps

module lrle_step (
	input  logic [7:0]             text_byte,
	input  lrle_pkg::dec_state_t   cur,
	output lrle_pkg::dec_state_t   nxt,
	output logic                   emit,
	output lrle_pkg::run_rec_t     rec
);

	lrle_pkg::coord_t                   run;
	logic [7:0]                         digit;
	logic [lrle_pkg::WIDE_BITS-1:0]     pend_wide;
	logic [lrle_pkg::WIDE_BITS-1:0]     acc;
	logic                               is_digit;

	assign run       = (cur.pending == '0) ? lrle_pkg::coord_t'(1) : cur.pending;
	assign digit     = text_byte - lrle_pkg::CH_ZERO;
	assign pend_wide = lrle_pkg::WIDE_BITS'(cur.pending);
	assign acc       = (pend_wide << 3) + (pend_wide << 1) + lrle_pkg::WIDE_BITS'(digit);
	assign is_digit  = (text_byte >= lrle_pkg::CH_ZERO) && (text_byte <= lrle_pkg::CH_NINE);

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		rec  = '0;
		if (!cur.finished) begin
			priority if (text_byte == lrle_pkg::CH_SPACE) begin
				nxt = cur;
			end else if (is_digit) begin
				// saturate the decimal count
				if (acc[lrle_pkg::WIDE_BITS-1:lrle_pkg::COORD_BITS] != '0) begin
					nxt.pending = '1;
				end else begin
					nxt.pending = acc[lrle_pkg::COORD_BITS-1:0];
				end
			end else if (text_byte == lrle_pkg::CH_LINE) begin
				nxt.pending = '0;
				nxt.row     = cur.row + run;
				nxt.column  = '0;
			end else if (text_byte == lrle_pkg::CH_END) begin
				nxt.pending     = '0;
				nxt.column      = cur.column + run;
				nxt.finished    = 1'b1;
				emit            = 1'b1;
				rec.pattern_end = 1'b1;
			end else if (text_byte == lrle_pkg::CH_LIVE) begin
				nxt.pending      = '0;
				nxt.column       = cur.column + run;
				emit             = 1'b1;
				rec.start_column = lrle_pkg::FIELD_BITS'(cur.column);
				rec.row_index    = lrle_pkg::FIELD_BITS'(cur.row);
				rec.live_count   = lrle_pkg::FIELD_BITS'(run);
			end else begin
				nxt.pending = '0;
				nxt.column  = cur.column + run;
			end
		end
	end

endmodule

[hw/rtl/life_rle_body_decoder_unit.sv]
`timescale 1ns / 1ps

// Decodes the body of a run-length-encoded life pattern, one byte per
// transaction, and takes a new byte every clock cycle. Each 'o' yields one
// run record (start column, row, live count) in the cycle after the byte is
// accepted; '!' yields an end record and all later bytes are dropped until
// reset. Digits, spaces, '$' and dead-cell tags yield no record. The state
// registers update in the cycle a byte is accepted and the record waits in
// an output register, so input is only held off while that register is
// full and run_ready is low.
module life_rle_body_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_byte,
	output logic        run_valid,
	input  logic        run_ready,
	output logic [15:0] start_column,
	output logic [15:0] row_index,
	output logic [15:0] live_count,
	output logic        pattern_end
);

	lrle_pkg::dec_state_t state_q;
	lrle_pkg::dec_state_t state_nxt;
	lrle_pkg::run_rec_t   rec_nxt;
	lrle_pkg::run_rec_t   rec_q;
	logic                 emit;
	logic                 valid_q;
	logic                 accept;

	lrle_step u_step (
		.text_byte (text_byte),
		.cur       (state_q),
		.nxt       (state_nxt),
		.emit      (emit),
		.rec       (rec_nxt)
	);

	assign text_ready = !valid_q || run_ready;
	assign accept     = text_valid && text_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
			end
			if (accept && emit) begin
				valid_q <= 1'b1;
			end else if (run_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			rec_q <= rec_nxt;
		end
	end

	assign run_valid    = valid_q;
	assign start_column = rec_q.start_column;
	assign row_index    = rec_q.row_index;
	assign live_count   = rec_q.live_count;
	assign pattern_end  = rec_q.pattern_end;

endmodule
